/* hw/rtl/dual_channel_block_average_scaler_defines.svh */
// Assertion macros for the dual channel block average scaler.
`ifndef DUAL_CHANNEL_BLOCK_AVERAGE_SCALER_DEFINES_SVH
`define DUAL_CHANNEL_BLOCK_AVERAGE_SCALER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DCBAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DCBAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dcbas_pkg.sv */
// Shared constants and types for the dual channel block average scaler.
`default_nettype none

package dcbas_pkg;

    localparam int MAX_ROWS  = 64;

    localparam int SAMPLE_W  = 12;
    localparam int LIMIT_W   = 12;
    localparam int GAIN_W    = 16;
    localparam int SCALED_W  = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int SUM_W     = SAMPLE_W + $clog2(MAX_ROWS);
    localparam int BIT_W     = $clog2(SUM_W);
    localparam int PROD_W    = LIMIT_W + GAIN_W;
    localparam int MAC_W     = PROD_W + 2;

    localparam logic [LIMIT_W-1:0]         LOWER_RESET  = 12'd100;
    localparam logic [LIMIT_W-1:0]         UPPER_RESET  = 12'd4000;
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 16'd3361;
    localparam logic signed [SCALED_W-1:0] OFFSET_RESET = -24'sd6889683;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOWER_LIMIT  = 2'd0,
        CFG_UPPER_LIMIT  = 2'd1,
        CFG_SCALE_GAIN   = 2'd2,
        CFG_SCALE_OFFSET = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_LOAD
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/dcbas_if.sv */
// Request channels for sample rows in and block averages out.
`default_nettype none

interface dcbas_row_if;
    logic                          valid;
    logic                          ready;
    logic [dcbas_pkg::SAMPLE_W-1:0] sample_first;
    logic [dcbas_pkg::SAMPLE_W-1:0] sample_second;
    logic                          last_row;

    modport source (output valid, output sample_first, output sample_second,
                    output last_row, input ready);
    modport sink   (input valid, input sample_first, input sample_second,
                    input last_row, output ready);
endinterface

interface dcbas_avg_if;
    logic                                 valid;
    logic                                 ready;
    logic [dcbas_pkg::SAMPLE_W-1:0]        raw_first;
    logic [dcbas_pkg::SAMPLE_W-1:0]        raw_second;
    logic signed [dcbas_pkg::SCALED_W-1:0] scaled_first;
    logic signed [dcbas_pkg::SCALED_W-1:0] scaled_second;

    modport source (output valid, output raw_first, output raw_second,
                    output scaled_first, output scaled_second, input ready);
    modport sink   (input valid, input raw_first, input raw_second,
                    input scaled_first, input scaled_second, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dual_channel_block_average_scaler.sv */
// Top level: dual channel block averager with clamp and linear scaling.
//
// Rows are taken one per cycle while the block is idle; each row is added into
// the two channel sums at once. A row with last_row set, or the row that brings
// the count to MAX_ROWS, closes the block. The block then drops ready until its
// result is loaded: one bit-serial restoring divider works through each channel
// in turn, then one 12x16 multiplier and one add/saturate stage run twice, once
// per channel, and the result is moved to the output register. That register
// holds the request until it is taken; the next block can accumulate meanwhile,
// and only its own result load waits on it. Configuration is written through
// cfg_wr_en/cfg_index/cfg_wr_data; the user must write it only while idle, which the block does not enforce.
`default_nettype none

`include "dual_channel_block_average_scaler_defines.svh"

module dual_channel_block_average_scaler (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dcbas_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dcbas_pkg::CFG_W-1:0]       cfg_wr_data,
    dcbas_row_if.sink                              rows,
    dcbas_avg_if.source                            averages
);

    localparam int SAMPLE_W = dcbas_pkg::SAMPLE_W;
    localparam int LIMIT_W  = dcbas_pkg::LIMIT_W;
    localparam int GAIN_W   = dcbas_pkg::GAIN_W;
    localparam int SCALED_W = dcbas_pkg::SCALED_W;
    localparam int ROW_W    = dcbas_pkg::ROW_W;
    localparam int SUM_W    = dcbas_pkg::SUM_W;
    localparam int BIT_W    = dcbas_pkg::BIT_W;
    localparam int PROD_W   = dcbas_pkg::PROD_W;
    localparam int MAC_W    = dcbas_pkg::MAC_W;

    // configuration
    logic [LIMIT_W-1:0]         lower_reg;
    logic [LIMIT_W-1:0]         upper_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [SCALED_W-1:0] offset_reg;

    // control
    dcbas_pkg::state_t state_reg, state_next;
    logic [ROW_W-1:0]  count_reg, count_next;
    logic [BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic              ch_reg, ch_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic [SUM_W-1:0]           sum_first_reg, sum_first_next;
    logic [SUM_W-1:0]           sum_second_reg, sum_second_next;
    logic [SUM_W-1:0]           hold_reg, hold_next;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic [ROW_W-1:0]           rem_reg, rem_next;
    logic [ROW_W-1:0]           div_reg, div_next;
    logic [SAMPLE_W-1:0]        avg_first_reg, avg_first_next;
    logic [SAMPLE_W-1:0]        avg_second_reg, avg_second_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic signed [SCALED_W-1:0] scl_first_reg, scl_first_next;
    logic signed [SCALED_W-1:0] scl_second_reg, scl_second_next;

    logic [SAMPLE_W-1:0]        raw_first_reg, raw_second_reg;
    logic signed [SCALED_W-1:0] out_first_reg, out_second_reg;

    // combinational helpers
    logic                       row_ready;
    logic                       row_acc;
    logic                       load_ok;
    logic                       do_load;
    logic [ROW_W-1:0]           count_plus;
    logic                       closes;
    logic [SUM_W-1:0]           add_first;
    logic [SUM_W-1:0]           add_second;
    logic [ROW_W:0]             trial;
    logic [ROW_W:0]             diff;
    logic                       div_ge;
    logic [SUM_W-1:0]           quo_shift;
    logic [SAMPLE_W-1:0]        avg_sel;
    logic [LIMIT_W-1:0]         clamp_lo;
    logic [LIMIT_W-1:0]         clamp_v;
    logic signed [MAC_W-1:0]    mac;
    logic signed [SCALED_W-1:0] sat;

    assign load_ok    = !out_valid_reg || averages.ready;
    assign row_acc    = rows.valid && row_ready;
    assign count_plus = count_reg + ROW_W'(1);
    assign closes     = rows.last_row || (count_plus == ROW_W'(dcbas_pkg::MAX_ROWS));
    assign add_first  = sum_first_reg + SUM_W'(rows.sample_first);
    assign add_second = sum_second_reg + SUM_W'(rows.sample_second);

    // restoring division step
    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign diff      = trial - {1'b0, div_reg};
    assign div_ge    = (trial >= {1'b0, div_reg});
    assign quo_shift = {quo_reg[SUM_W-2:0], div_ge};

    // clamp, lower limit first
    assign avg_sel  = ch_reg ? avg_second_reg : avg_first_reg;
    assign clamp_lo = (LIMIT_W'(avg_sel) < lower_reg) ? lower_reg : LIMIT_W'(avg_sel);
    assign clamp_v  = (clamp_lo > upper_reg) ? upper_reg : clamp_lo;

    assign mac = $signed({2'b00, prod_reg})
               + {{(MAC_W-SCALED_W){offset_reg[SCALED_W-1]}}, offset_reg};

    // saturate when the bits above the result do not all match its sign
    always_comb
    begin
        if (mac[MAC_W-1:SCALED_W-1] == '0 || mac[MAC_W-1:SCALED_W-1] == '1)
        begin
            sat = mac[SCALED_W-1:0];
        end
        else if (mac[MAC_W-1])
        begin
            sat = {1'b1, {(SCALED_W-1){1'b0}}};
        end
        else
        begin
            sat = {1'b0, {(SCALED_W-1){1'b1}}};
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dcbas_pkg::ST_IDLE:
            begin
                if (row_acc && closes)
                begin
                    state_next = dcbas_pkg::ST_DIV;
                end
            end
            dcbas_pkg::ST_DIV:
            begin
                if (bit_cnt_reg == '0 && ch_reg)
                begin
                    state_next = dcbas_pkg::ST_MUL;
                end
            end
            dcbas_pkg::ST_MUL:
            begin
                state_next = dcbas_pkg::ST_ADD;
            end
            dcbas_pkg::ST_ADD:
            begin
                state_next = ch_reg ? dcbas_pkg::ST_LOAD : dcbas_pkg::ST_MUL;
            end
            dcbas_pkg::ST_LOAD:
            begin
                if (load_ok)
                begin
                    state_next = dcbas_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcbas_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        row_ready = 1'b0;
        do_load   = 1'b0;
        unique case (state_reg)
            dcbas_pkg::ST_IDLE: row_ready = 1'b1;
            dcbas_pkg::ST_LOAD: do_load   = load_ok;
            default:
            begin
                row_ready = 1'b0;
                do_load   = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        count_next      = count_reg;
        bit_cnt_next    = bit_cnt_reg;
        ch_next         = ch_reg;
        sum_first_next  = sum_first_reg;
        sum_second_next = sum_second_reg;
        hold_next       = hold_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        avg_first_next  = avg_first_reg;
        avg_second_next = avg_second_reg;
        prod_next       = prod_reg;
        scl_first_next  = scl_first_reg;
        scl_second_next = scl_second_reg;
        case (state_reg)
            dcbas_pkg::ST_IDLE:
            begin
                if (row_acc)
                begin
                    if (closes)
                    begin
                        // hand the sums to the divider and start a fresh block
                        quo_next        = add_first;
                        hold_next       = add_second;
                        div_next        = count_plus;
                        rem_next        = '0;
                        bit_cnt_next    = BIT_W'(SUM_W - 1);
                        ch_next         = 1'b0;
                        sum_first_next  = '0;
                        sum_second_next = '0;
                        count_next      = '0;
                    end
                    else
                    begin
                        sum_first_next  = add_first;
                        sum_second_next = add_second;
                        count_next      = count_plus;
                    end
                end
            end
            dcbas_pkg::ST_DIV:
            begin
                rem_next = div_ge ? diff[ROW_W-1:0] : trial[ROW_W-1:0];
                quo_next = quo_shift;
                if (bit_cnt_reg == '0)
                begin
                    if (ch_reg)
                    begin
                        avg_second_next = quo_shift[SAMPLE_W-1:0];
                        ch_next         = 1'b0;
                    end
                    else
                    begin
                        avg_first_next = quo_shift[SAMPLE_W-1:0];
                        quo_next       = hold_reg;
                        rem_next       = '0;
                        bit_cnt_next   = BIT_W'(SUM_W - 1);
                        ch_next        = 1'b1;
                    end
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_W'(1);
                end
            end
            dcbas_pkg::ST_MUL:
            begin
                prod_next = PROD_W'(clamp_v) * PROD_W'(gain_reg);
            end
            dcbas_pkg::ST_ADD:
            begin
                if (ch_reg)
                begin
                    scl_second_next = sat;
                end
                else
                begin
                    scl_first_next = sat;
                end
                ch_next = !ch_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !averages.ready;
        if (do_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= dcbas_pkg::LOWER_RESET;
            upper_reg  <= dcbas_pkg::UPPER_RESET;
            gain_reg   <= dcbas_pkg::GAIN_RESET;
            offset_reg <= dcbas_pkg::OFFSET_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (dcbas_pkg::cfg_index_t'(cfg_index))
                dcbas_pkg::CFG_LOWER_LIMIT:  lower_reg  <= cfg_wr_data[LIMIT_W-1:0];
                dcbas_pkg::CFG_UPPER_LIMIT:  upper_reg  <= cfg_wr_data[LIMIT_W-1:0];
                dcbas_pkg::CFG_SCALE_GAIN:   gain_reg   <= cfg_wr_data[GAIN_W-1:0];
                dcbas_pkg::CFG_SCALE_OFFSET: offset_reg <= $signed(cfg_wr_data[SCALED_W-1:0]);
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dcbas_pkg::ST_IDLE;
            count_reg      <= '0;
            bit_cnt_reg    <= '0;
            ch_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            sum_first_reg  <= '0;
            sum_second_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            bit_cnt_reg    <= bit_cnt_next;
            ch_reg         <= ch_next;
            out_valid_reg  <= out_valid_next;
            sum_first_reg  <= sum_first_next;
            sum_second_reg <= sum_second_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_reg       <= hold_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        avg_first_reg  <= avg_first_next;
        avg_second_reg <= avg_second_next;
        prod_reg       <= prod_next;
        scl_first_reg  <= scl_first_next;
        scl_second_reg <= scl_second_next;
        if (do_load)
        begin
            raw_first_reg  <= avg_first_reg;
            raw_second_reg <= avg_second_reg;
            out_first_reg  <= scl_first_reg;
            out_second_reg <= scl_second_reg;
        end
    end

    assign rows.ready             = row_ready;
    assign averages.valid         = out_valid_reg;
    assign averages.raw_first     = raw_first_reg;
    assign averages.raw_second    = raw_second_reg;
    assign averages.scaled_first  = out_first_reg;
    assign averages.scaled_second = out_second_reg;

    `DCBAS_ASSERT_NOW(a_count_bound, 1'b1, count_reg < ROW_W'(dcbas_pkg::MAX_ROWS), "row count reached the block limit")
    `DCBAS_ASSERT_NEXT(a_close_starts_div, row_acc && closes, state_reg == dcbas_pkg::ST_DIV && count_reg == '0 && sum_first_reg == '0, "closing row did not start the divider")
    `DCBAS_ASSERT_NOW(a_divisor_nonzero, state_reg == dcbas_pkg::ST_DIV, div_reg != '0, "divider running with a zero row count")
    `DCBAS_ASSERT_NEXT(a_load_shows, do_load, out_valid_reg && raw_first_reg == $past(avg_first_reg), "block result not presented after load")

endmodule

`default_nettype wire

/* bench/dcbas_average_checker.sv */
// Checker: predicts block averages from accepted rows and compares each average request.
module dcbas_average_checker
    import dcbas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    dcbas_row_if                 rows,
    dcbas_avg_if                 averages,
    output int                   fail_total,
    output int                   pending
);

    localparam longint SCALED_MAX = (64'sd1 <<< (SCALED_W - 1)) - 1;
    localparam longint SCALED_MIN = -(64'sd1 <<< (SCALED_W - 1));
    localparam int     REPORT_MAX = 10;

    typedef struct packed {
        logic [SAMPLE_W-1:0]        raw_first;
        logic [SAMPLE_W-1:0]        raw_second;
        logic signed [SCALED_W-1:0] scaled_first;
        logic signed [SCALED_W-1:0] scaled_second;
    } block_avg_t;

    logic [LIMIT_W-1:0]         lower_limit;
    logic [LIMIT_W-1:0]         upper_limit;
    logic [GAIN_W-1:0]          scale_gain;
    logic signed [SCALED_W-1:0] scale_offset;

    int         sum_first;
    int         sum_second;
    int         rows_in_block;
    block_avg_t expected_averages[$];

    // Clamp first to the lower limit, then to the upper one, so crossed limits give upper.
    function automatic logic signed [SCALED_W-1:0] scale_average(int avg);
        longint level;
        longint mapped;
        level = avg;
        if (level < longint'(lower_limit))
            level = longint'(lower_limit);
        if (level > longint'(upper_limit))
            level = longint'(upper_limit);
        mapped = level * longint'(scale_gain) + longint'(scale_offset);
        if (mapped > SCALED_MAX)
            mapped = SCALED_MAX;
        if (mapped < SCALED_MIN)
            mapped = SCALED_MIN;
        return mapped[SCALED_W-1:0];
    endfunction

    function automatic void flag_failure(string what, block_avg_t want, block_avg_t got);
        fail_total++;
        if (fail_total <= REPORT_MAX)
            $display("%s: expected raw %0d/%0d scaled %0d/%0d, got raw %0d/%0d scaled %0d/%0d",
                     what, want.raw_first, want.raw_second, $signed(want.scaled_first),
                     $signed(want.scaled_second), got.raw_first, got.raw_second,
                     $signed(got.scaled_first), $signed(got.scaled_second));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        block_avg_t got;
        block_avg_t want;
        int         avg_first;
        int         avg_second;
        if (!rst_n)
        begin
            lower_limit   = LOWER_RESET;
            upper_limit   = UPPER_RESET;
            scale_gain    = GAIN_RESET;
            scale_offset  = OFFSET_RESET;
            sum_first     = 0;
            sum_second    = 0;
            rows_in_block = 0;
            expected_averages.delete();
            fail_total    = 0;
            pending       = 0;
        end
        else
        begin
            if (averages.valid && averages.ready)
            begin
                got.raw_first     = averages.raw_first;
                got.raw_second    = averages.raw_second;
                got.scaled_first  = averages.scaled_first;
                got.scaled_second = averages.scaled_second;
                if (expected_averages.size() == 0)
                    flag_failure("average request with none waiting", '0, got);
                else
                begin
                    want = expected_averages.pop_front();
                    if (got.raw_first !== want.raw_first || got.raw_second !== want.raw_second
                        || got.scaled_first !== want.scaled_first
                        || got.scaled_second !== want.scaled_second)
                        flag_failure("average mismatch", want, got);
                end
            end

            if (rows.valid && rows.ready)
            begin
                sum_first     += int'(rows.sample_first);
                sum_second    += int'(rows.sample_second);
                rows_in_block += 1;
                // A full block closes even without the last-row flag.
                if (rows.last_row || rows_in_block == MAX_ROWS)
                begin
                    avg_first          = sum_first / rows_in_block;
                    avg_second         = sum_second / rows_in_block;
                    want.raw_first     = avg_first[SAMPLE_W-1:0];
                    want.raw_second    = avg_second[SAMPLE_W-1:0];
                    want.scaled_first  = scale_average(avg_first);
                    want.scaled_second = scale_average(avg_second);
                    expected_averages.push_back(want);
                    sum_first     = 0;
                    sum_second    = 0;
                    rows_in_block = 0;
                end
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_LOWER_LIMIT:  lower_limit  = cfg_wr_data[LIMIT_W-1:0];
                    CFG_UPPER_LIMIT:  upper_limit  = cfg_wr_data[LIMIT_W-1:0];
                    CFG_SCALE_GAIN:   scale_gain   = cfg_wr_data[GAIN_W-1:0];
                    CFG_SCALE_OFFSET: scale_offset = cfg_wr_data[SCALED_W-1:0];
                    default: ;
                endcase
            end

            pending = expected_averages.size();
        end
    end

endmodule

/* bench/dual_channel_block_average_scaler_tb.sv */
// Testbench top: drives sample rows and settings into the block averager and gives the verdict.
module dual_channel_block_average_scaler_tb;
    import dcbas_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    // Settling wait at the end of each drain, after the last expected average is taken.
    localparam int SETTLE_CYCLES = 60;
    localparam int SAMPLE_TOP    = (1 << SAMPLE_W) - 1;
    localparam int GAIN_TOP      = (1 << GAIN_W) - 1;
    localparam int OFFSET_TOP    = (1 << (SCALED_W - 1)) - 1;
    localparam int OFFSET_BOTTOM = -(1 << (SCALED_W - 1));
    localparam int PHASE_ROWS    = 66;
    localparam int RANDOM_PHASES = 6;

    typedef enum {SPREAD_FULL, SPREAD_NEAR, SPREAD_RAIL} row_shape_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wr_data;
    int                   fail_total;
    int                   pending;
    int                   cycle_count;
    bit                   quiet;

    dcbas_row_if rows_ch ();
    dcbas_avg_if avg_ch ();

    dual_channel_block_average_scaler u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .rows        (rows_ch),
        .averages    (avg_ch)
    );

    dcbas_average_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .rows        (rows_ch),
        .averages    (avg_ch),
        .fail_total  (fail_total),
        .pending     (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int clip_sample(int v);
        return (v < 0) ? 0 : ((v > SAMPLE_TOP) ? SAMPLE_TOP : v);
    endfunction

    // Leave valid high after acceptance; the next row either replaces it or drops it.
    task automatic send_row(int first, int second, bit last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            rows_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        rows_ch.sample_first  = first[SAMPLE_W-1:0];
        rows_ch.sample_second = second[SAMPLE_W-1:0];
        rows_ch.last_row      = last;
        rows_ch.valid         = 1'b1;
        do @(posedge clk); while (!rows_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        rows_ch.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(cfg_index_t idx, int value);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = value[CFG_W-1:0];
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic write_settings(int lower, int upper, int gain, int offset);
        put_reg(CFG_LOWER_LIMIT, lower);
        put_reg(CFG_UPPER_LIMIT, upper);
        put_reg(CFG_SCALE_GAIN, gain);
        put_reg(CFG_SCALE_OFFSET, offset);
    endtask

    task automatic random_rows(int count);
        int         left;
        int         blen;
        int         centre;
        int         spread;
        int         a;
        int         b;
        bit         close_it;
        bit         last;
        row_shape_t shape;
        left = count;
        while (left > 0)
        begin
            // Now and then run a block near or past MAX_ROWS so the row limit can close it.
            if ($urandom_range(0, 24) == 0)
            begin
                blen     = $urandom_range(MAX_ROWS - 4, MAX_ROWS + 6);
                close_it = $urandom_range(0, 1);
            end
            else
            begin
                blen     = $urandom_range(1, 8);
                close_it = 1'b1;
            end
            shape  = row_shape_t'($urandom_range(0, 2));
            centre = $urandom_range(0, SAMPLE_TOP);
            spread = $urandom_range(0, 200);
            for (int i = 0; i < blen && left > 0; i++)
            begin
                case (shape)
                    SPREAD_FULL:
                    begin
                        a = $urandom_range(0, SAMPLE_TOP);
                        b = $urandom_range(0, SAMPLE_TOP);
                    end
                    SPREAD_NEAR:
                    begin
                        a = clip_sample(centre + $urandom_range(0, 2 * spread) - spread);
                        b = clip_sample(SAMPLE_TOP - centre + $urandom_range(0, 2 * spread)
                                        - spread);
                    end
                    default:
                    begin
                        a = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
                        b = $urandom_range(0, 1) ? SAMPLE_TOP : 0;
                    end
                endcase
                // Stray last-row flags break blocks early.
                last = (i == blen - 1 && close_it) || ($urandom_range(0, 29) == 0);
                send_row(a, b, last);
                left--;
            end
        end
    endtask

    // Average request taker: draw a stall per request, hold ready until one is taken.
    initial
    begin
        int hold;
        avg_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 13);
            if (hold != 0)
            begin
                avg_ch.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            avg_ch.ready = 1'b1;
            do @(posedge clk); while (!avg_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        int     lower;
        int     upper;
        int     gain;
        int     offset;
        int     swap;
        longint mid;
        rst_n                 = 1'b0;
        quiet                 = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = CFG_LOWER_LIMIT;
        cfg_wr_data           = '0;
        rows_ch.valid         = 1'b0;
        rows_ch.sample_first  = '0;
        rows_ch.sample_second = '0;
        rows_ch.last_row      = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Settings as left by reset: rails, truncation, limits and alternating bits.
        send_row(0, SAMPLE_TOP, 1'b1);
        send_row(SAMPLE_TOP, 0, 1'b1);
        send_row(1, 2, 1'b0);
        send_row(2, 2, 1'b0);
        send_row(2, 3, 1'b1);
        send_row(99, 101, 1'b1);
        send_row(4000, 4001, 1'b1);
        send_row(12'hAAA, 12'h555, 1'b1);
        drain();

        // Widest window, top gain and offset: the map saturates high.
        write_settings(0, SAMPLE_TOP, GAIN_TOP, OFFSET_TOP);
        send_row(0, 0, 1'b1);
        send_row(SAMPLE_TOP, SAMPLE_TOP, 1'b1);
        send_row(1, 1, 1'b1);
        drain();

        // Crossed limits with zero gain and the lowest offset.
        write_settings(SAMPLE_TOP, 0, 0, OFFSET_BOTTOM);
        send_row(0, SAMPLE_TOP, 1'b1);
        send_row(2048, 17, 1'b1);
        drain();

        write_settings(3000, 1000, 1, 0);
        send_row(3500, 500, 1'b1);
        send_row(2000, 2001, 1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            lower = $urandom_range(0, SAMPLE_TOP);
            upper = $urandom_range(0, SAMPLE_TOP);
            if ($urandom_range(0, 3) != 0 && lower > upper)
            begin
                swap  = lower;
                lower = upper;
                upper = swap;
            end
            gain = $urandom_range(0, GAIN_TOP) >> $urandom_range(0, 8);
            if ($urandom_range(0, 2) == 0)
                offset = int'($signed(24'($urandom)));
            else
            begin
                // Centre the mapped window on zero so most results stay unsaturated.
                mid    = longint'(gain) * longint'(lower + upper) / 2;
                offset = (mid > longint'(OFFSET_TOP) + 1) ? OFFSET_BOTTOM : -int'(mid);
            end
            write_settings(lower, upper, gain, offset);
            quiet = ($urandom_range(0, 3) == 0);
            random_rows(PHASE_ROWS);
            drain();
        end

        if (fail_total == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dcbas_pkg.sv
hw/rtl/dcbas_if.sv
hw/rtl/dual_channel_block_average_scaler.sv
bench/dcbas_average_checker.sv
bench/dual_channel_block_average_scaler_tb.sv
